>>> rtl/lbc_pkg.sv
package lbc_pkg;

  localparam int MAX_WIDTH_DEF = 2048;

  localparam int PIX_W   = 8;
  localparam int CODE_W  = 8;
  localparam int COL_W   = 11;
  localparam int ROW_W   = 16;
  localparam int CFG_WW  = 12;
  localparam int CFG_HW  = 16;
  localparam int APB_DW  = 32;
  localparam int PADDR_W = 3;

  localparam logic [CFG_WW-1:0] WIDTH_RESET  = CFG_WW'(640);
  localparam logic [CFG_HW-1:0] HEIGHT_RESET = CFG_HW'(480);

  // results one pixel can cause
  localparam int MAX_RES = 3;
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              run_last;
    logic              frame_done;
  } res_t;

  typedef struct packed {
    logic             valid;
    logic             interior;
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] mid;
  } win_req_t;

endpackage

>>> rtl/lbc_if.sv
interface lbc_pixel_if;
  logic                     valid;
  logic                     ready;
  logic [lbc_pkg::PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface lbc_result_if;
  logic                      valid;
  logic                      ready;
  logic [lbc_pkg::CODE_W-1:0] pattern_code;
  logic [lbc_pkg::ROW_W-1:0]  out_row;
  logic [lbc_pkg::COL_W-1:0]  out_col;
  logic                      run_last;
  logic                      frame_done;

  modport source (output valid, output pattern_code, output out_row, output out_col,
                  output run_last, output frame_done, input ready);
  modport sink   (input valid, input pattern_code, input out_row, input out_col,
                  input run_last, input frame_done, output ready);
endinterface

>>> rtl/lbp_code_3x3_unit.sv
// 3x3 local binary pattern unit. Takes 8-bit grey pixels in raster order and
// returns one code per pixel of the frame, tagged with its row and column;
// border pixels get code 0. Codes leave as soon as their window is complete,
// so the order is not strictly raster. A pixel is accepted every clock while
// the result queue has room; the two line stores live in one 16-bit wide
// memory that is read at the pixel's column in the accept cycle and written
// back the next cycle. A row end adds a second result and every pixel of the
// last row adds one more, all through a 8-entry result queue whose single
// output port moves one result per clock while the sink is ready, so the last
// row holds back the input. Width and height sit at APB offsets 0x0 and 0x4;
// the user must write them between frames, which the block does not enforce.
module lbp_code_3x3_unit #(
  parameter int MAX_WIDTH = lbc_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  lbc_pixel_if.sink                   pixels,
  lbc_result_if.source                codes,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lbc_pkg::PADDR_W-1:0] paddr,
  input  logic [lbc_pkg::APB_DW-1:0]  pwdata,
  output logic [lbc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import lbc_pkg::*;

  localparam int AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int LimW = (MAX_WIDTH > 4095) ? 4095 : MAX_WIDTH;

  logic [CFG_WW-1:0] image_width;
  logic [CFG_HW-1:0] image_height;
  logic [CFG_WW-1:0] last_col;
  logic [CFG_HW-1:0] last_row_idx;

  // accept stage
  logic             accept;
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic             end_row;
  logic             last_row;
  logic             in_range;
  logic [AW-1:0]    addr;

  // result stage
  logic             s1_valid;
  logic [PIX_W-1:0] s1_px;
  logic [ROW_W-1:0] s1_row;
  logic [COL_W-1:0] s1_col;
  logic [AW-1:0]    s1_addr;
  logic             s1_in_range;
  logic             s1_has_a;
  logic             s1_has_b;
  logic             s1_has_c;
  logic             s1_interior;
  logic             s1_frame_end;

  logic [2*PIX_W-1:0] rd_data;
  logic [PIX_W-1:0]   up;
  logic [PIX_W-1:0]   mid;
  win_req_t           win_req;
  logic [CODE_W-1:0]  code;

  res_t                  ent [MAX_RES];
  logic [CNT_W-1:0]      n_res;
  res_t                  head;
  logic                  not_empty;
  logic [FIFO_LVL_W-1:0] level;
  logic                  pop;

  lbc_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .image_width  (image_width),
    .image_height (image_height)
  );

  // clamp width to [3, min(MAX_WIDTH, 4095)], height to at least 3
  always_comb begin
    if (image_width < CFG_WW'(3)) begin
      last_col = CFG_WW'(2);
    end else if (image_width > CFG_WW'(LimW)) begin
      last_col = CFG_WW'(LimW - 1);
    end else begin
      last_col = image_width - CFG_WW'(1);
    end
    if (image_height < CFG_HW'(3)) begin
      last_row_idx = CFG_HW'(2);
    end else begin
      last_row_idx = image_height - CFG_HW'(1);
    end
  end

  // room for the worst case of the item in flight plus the new one
  assign pixels.ready = (FIFO_LVL_W'(level) + (s1_valid ? (FIFO_LVL_W + 1)'(MAX_RES) : '0))
                        <= (FIFO_LVL_W + 1)'(FIFO_DEPTH - MAX_RES);
  assign accept   = pixels.valid & pixels.ready;
  assign end_row  = CFG_WW'(col_count) >= last_col;
  assign last_row = row_count >= last_row_idx;
  assign in_range = 32'(col_count) < MAX_WIDTH;
  assign addr     = AW'(col_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      s1_valid  <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (end_row) begin
          col_count <= '0;
          row_count <= last_row ? '0 : row_count + ROW_W'(1);
        end else begin
          col_count <= col_count + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px        <= pixels.pixel;
      s1_row       <= row_count;
      s1_col       <= col_count;
      s1_addr      <= addr;
      s1_in_range  <= in_range;
      s1_has_a     <= (row_count != '0) && (col_count != '0);
      s1_has_b     <= end_row && (row_count != '0);
      s1_has_c     <= last_row;
      s1_frame_end <= end_row && last_row;
      s1_interior  <= (row_count >= ROW_W'(2)) && (row_count <= last_row_idx) &&
                      (col_count >= COL_W'(2)) && (CFG_WW'(col_count) <= last_col);
    end
  end

  // consecutive pixels never share a column, so no read/write overlap
  lbc_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_lines (
    .clk     (clk),
    .rd_en   (accept & in_range),
    .rd_addr (addr),
    .rd_data (rd_data),
    .wr_en   (s1_valid & s1_in_range),
    .wr_addr (s1_addr),
    .wr_data ({mid, s1_px})
  );

  assign up  = s1_in_range ? rd_data[2*PIX_W-1:PIX_W] : '0;
  assign mid = s1_in_range ? rd_data[PIX_W-1:0] : '0;

  always_comb begin
    win_req.valid    = s1_valid;
    win_req.interior = s1_interior;
    win_req.px       = s1_px;
    win_req.up       = up;
    win_req.mid      = mid;
  end

  lbc_window u_window (
    .clk  (clk),
    .rst  (rst),
    .req  (win_req),
    .code (code)
  );

  // pack the results of this pixel in order: center, row-end, last-row
  always_comb begin
    logic [CNT_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      ent[i] = '0;
    end
    if (s1_has_a) begin
      ent[idx].code = code;
      ent[idx].row  = s1_row - ROW_W'(1);
      ent[idx].col  = s1_col - COL_W'(1);
      idx = idx + CNT_W'(1);
    end
    if (s1_has_b) begin
      ent[idx].row = s1_row - ROW_W'(1);
      ent[idx].col = s1_col;
      idx = idx + CNT_W'(1);
    end
    if (s1_has_c) begin
      ent[idx].row = s1_row;
      ent[idx].col = s1_col;
      idx = idx + CNT_W'(1);
    end
    if (idx != '0) begin
      ent[idx - CNT_W'(1)].run_last   = 1'b1;
      ent[idx - CNT_W'(1)].frame_done = s1_frame_end;
    end
    n_res = s1_valid ? idx : '0;
  end

  assign pop = codes.valid & codes.ready;

  lbc_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push_data (ent),
    .push_cnt  (n_res),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .level     (level)
  );

  assign codes.valid        = not_empty;
  assign codes.pattern_code = head.code;
  assign codes.out_row      = head.row;
  assign codes.out_col      = head.col;
  assign codes.run_last     = head.run_last;
  assign codes.frame_done   = head.frame_done;

endmodule

>>> rtl/lbc_cfg_regs.sv
module lbc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lbc_pkg::PADDR_W-1:0] paddr,
  input  logic [lbc_pkg::APB_DW-1:0]  pwdata,
  output logic [lbc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output logic [lbc_pkg::CFG_WW-1:0]  image_width,
  output logic [lbc_pkg::CFG_HW-1:0]  image_height
);
  import lbc_pkg::*;

  reg_idx_t sel;
  logic     wr;

  // byte offset bits are ignored
  assign sel    = reg_idx_t'(paddr[2]);
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (wr) begin
      case (sel)
        REG_IMAGE_WIDTH:  image_width  <= pwdata[CFG_WW-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[CFG_HW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_IMAGE_WIDTH:  prdata = APB_DW'(image_width);
      REG_IMAGE_HEIGHT: prdata = APB_DW'(image_height);
      default:          prdata = '0;
    endcase
  end

endmodule

>>> rtl/lbc_line_store.sv
module lbc_line_store #(
  parameter int MAX_WIDTH = lbc_pkg::MAX_WIDTH_DEF
) (
  input  logic                                          clk,
  input  logic                                          rd_en,
  input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] rd_addr,
  output logic [2*lbc_pkg::PIX_W-1:0]                   rd_data,
  input  logic                                          wr_en,
  input  logic [((MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1)-1:0] wr_addr,
  input  logic [2*lbc_pkg::PIX_W-1:0]                   wr_data
);
  import lbc_pkg::*;

  // one entry per column: {upper row, middle row}
  logic [2*PIX_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/lbc_window.sv
module lbc_window (
  input  logic                       clk,
  input  logic                       rst,
  input  lbc_pkg::win_req_t          req,
  output logic [lbc_pkg::CODE_W-1:0] code
);
  import lbc_pkg::*;

  // 0..2: column c-1 top/mid/bottom, 3..5: column c-2
  logic [PIX_W-1:0] win [6];
  logic [PIX_W-1:0] ctr;
  logic [CODE_W-1:0] raw;

  assign ctr = win[1];

  always_comb begin
    raw[0] = ctr < win[4];   // left
    raw[1] = ctr < win[5];   // below-left
    raw[2] = ctr < win[2];   // below
    raw[3] = ctr < req.px;   // below-right
    raw[4] = ctr < req.mid;  // right
    raw[5] = ctr < req.up;   // above-right
    raw[6] = ctr < win[0];   // above
    raw[7] = ctr < win[3];   // above-left
    code   = req.interior ? raw : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (req.valid) begin
      win[3] <= win[0];
      win[4] <= win[1];
      win[5] <= win[2];
      win[0] <= req.up;
      win[1] <= req.mid;
      win[2] <= req.px;
    end
  end

endmodule

>>> rtl/lbc_result_fifo.sv
module lbc_result_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  lbc_pkg::res_t                   push_data [lbc_pkg::MAX_RES],
  input  logic [lbc_pkg::CNT_W-1:0]       push_cnt,
  input  logic                            pop,
  output lbc_pkg::res_t                   head,
  output logic                            not_empty,
  output logic [lbc_pkg::FIFO_LVL_W-1:0]  level
);
  import lbc_pkg::*;

  res_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr;
  logic [FIFO_PTR_W-1:0] rptr;

  assign head      = mem[rptr];
  assign not_empty = level != '0;

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (CNT_W'(i) < push_cnt) begin
        mem[wptr + FIFO_PTR_W'(i)] <= push_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      level <= '0;
    end else begin
      wptr  <= wptr + FIFO_PTR_W'(push_cnt);
      rptr  <= rptr + FIFO_PTR_W'(pop);
      level <= level + FIFO_LVL_W'(push_cnt) - FIFO_LVL_W'(pop);
    end
  end

endmodule

>>> rtl/lbc_checker.sv
module lbc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [lbc_pkg::CODE_W-1:0] pattern_code,
  input logic [lbc_pkg::ROW_W-1:0]  out_row,
  input logic [lbc_pkg::COL_W-1:0]  out_col,
  input logic                       run_last,
  input logic                       frame_done
);
  import lbc_pkg::*;

  // a waiting result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pattern_code) && $stable(out_row) &&
      $stable(out_col) && $stable(run_last) && $stable(frame_done))
    else $error("result beat dropped or changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat right after reset");

  a_frame_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> run_last)
    else $error("frame end not on the last result of its pixel");

  // a nonzero code only comes from an interior center
  a_border_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (pattern_code != '0) |-> (out_row != '0) && (out_col != '0))
    else $error("nonzero code on first row or column");

endmodule

bind lbp_code_3x3_unit lbc_checker u_lbc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (codes.valid),
  .out_ready    (codes.ready),
  .pattern_code (codes.pattern_code),
  .out_row      (codes.out_row),
  .out_col      (codes.out_col),
  .run_last     (codes.run_last),
  .frame_done   (codes.frame_done)
);

>>> tb/tb_lbp_code_3x3_unit.sv
`timescale 1ns / 1ps

module tb_lbp_code_3x3_unit;
  import lbc_pkg::*;

  localparam int MAXW = MAX_WIDTH_DEF;
  localparam int QUIET_CYCLES = 24;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 180;
  localparam longint TIMEOUT_NS = 64'd20_000_000;
  // raster slot (0..8) of neighbour k in a 3x3 grid, k = 7 first
  localparam logic [7:0][3:0] NB_SLOT = {4'd0, 4'd1, 4'd2, 4'd5, 4'd8, 4'd7, 4'd6, 4'd3};

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  lbc_pixel_if pix_bus ();
  lbc_result_if code_bus ();

  lbp_code_3x3_unit #(.MAX_WIDTH(MAXW)) dut (
    .clk(clk),
    .rst(rst),
    .pixels(pix_bus),
    .codes(code_bus),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // predictor state
  logic [CFG_WW-1:0] cfg_width;
  logic [CFG_HW-1:0] cfg_height;
  logic [PIX_W-1:0] upper_row_buf [0:MAXW-1];
  logic [PIX_W-1:0] middle_row_buf [0:MAXW-1];
  logic [PIX_W-1:0] win_px [0:5];  // 0..2: column c-1 top/mid/bottom, 3..5: column c-2
  logic [COL_W-1:0] col_cnt;
  logic [ROW_W-1:0] row_cnt;

  logic [PIX_W-1:0] pixel_q [$];
  res_t code_expect_q [$];

  int send_gap_max;
  int recv_stall_max;
  int gap_left;
  int stall_left;
  logic hold_off;
  int mismatches;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic int unsigned eff_width();
    int unsigned w;
    w = cfg_width;
    if (w < 3) w = 3;
    if (w > MAXW) w = MAXW;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    return (cfg_height < 3) ? 3 : cfg_height;
  endfunction

  function automatic res_t code_result(input logic [CODE_W-1:0] code, input int unsigned row,
                                       input int unsigned col);
    res_t res;
    res.code = code;
    res.row = ROW_W'(row);
    res.col = COL_W'(col);
    res.run_last = 1'b0;
    res.frame_done = 1'b0;
    return res;
  endfunction

  // pixels still to send before the current frame closes
  function automatic int unsigned frame_pixels_left();
    int unsigned w, h, c, r, row_rest, rows_after;
    w = eff_width();
    h = eff_height();
    c = col_cnt;
    r = row_cnt;
    row_rest = (c >= w - 1) ? 1 : w - c;
    rows_after = (r >= h - 1) ? 0 : h - 1 - r;
    return row_rest + rows_after * w;
  endfunction

  // advance the LBP window by one accepted pixel and queue the codes it completes
  task automatic lbp_take_pixel(input logic [PIX_W-1:0] px);
    int unsigned w, h, c, r;
    logic [PIX_W-1:0] up, mid, ctr;
    logic [CODE_W-1:0] code;
    logic end_row, last_row;
    res_t batch [$];
    w = eff_width();
    h = eff_height();
    c = col_cnt;
    r = row_cnt;
    up = upper_row_buf[c];
    mid = middle_row_buf[c];
    end_row = c >= w - 1;
    last_row = r >= h - 1;

    if (r >= 1 && c >= 1) begin
      code = 8'd0;
      if (r >= 2 && r - 1 <= h - 2 && c >= 2 && c <= w - 1) begin
        ctr = win_px[1];
        // bit 7 down to bit 0: above-left ... left
        code = {ctr < win_px[3], ctr < win_px[0], ctr < up, ctr < mid,
                ctr < px, ctr < win_px[2], ctr < win_px[5], ctr < win_px[4]};
      end
      batch = {batch, code_result(code, r - 1, c - 1)};
    end
    if (end_row && r >= 1) batch = {batch, code_result(8'd0, r - 1, c)};
    if (last_row) batch = {batch, code_result(8'd0, r, c)};

    upper_row_buf[c] = mid;
    middle_row_buf[c] = px;
    win_px[3] = win_px[0];
    win_px[4] = win_px[1];
    win_px[5] = win_px[2];
    win_px[0] = up;
    win_px[1] = mid;
    win_px[2] = px;

    if (end_row) begin
      col_cnt = '0;
      row_cnt = last_row ? '0 : ROW_W'(r + 1);
    end else begin
      col_cnt = COL_W'(c + 1);
    end

    if (batch.size() > 0) begin
      batch[batch.size() - 1].run_last = 1'b1;
      batch[batch.size() - 1].frame_done = end_row && last_row;
    end
    foreach (batch[i]) code_expect_q = {code_expect_q, batch[i]};
  endtask

  // APB write, then read back through the same port
  task automatic cfg_write(input reg_idx_t idx, input logic [APB_DW-1:0] value);
    logic [APB_DW-1:0] readback, stored;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(int'(idx) * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    // back-to-back read setup
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) begin
      cfg_width = value[CFG_WW-1:0];
      stored = APB_DW'(cfg_width);
    end else begin
      cfg_height = value[CFG_HW-1:0];
      stored = APB_DW'(cfg_height);
    end
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    readback = prdata;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== stored)
      note_mismatch($sformatf("reg %s reads %0h, want %0h", idx.name(), readback, stored));
  endtask

  task automatic enqueue_pixels(input int unsigned count);
    logic [PIX_W-1:0] px;
    @(negedge clk);
    repeat (count) begin
      case ($urandom_range(0, 3))
        0: px = PIX_W'($urandom_range(126, 129));
        1: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default: px = PIX_W'($urandom_range(0, 255));
      endcase
      pixel_q = {pixel_q, px};
    end
  endtask

  // 3x3 frame: center ctr, neighbour k gets hi where hi_mask[k] is set, else lo
  task automatic enqueue_window_frame(input logic [PIX_W-1:0] ctr, input logic [7:0] hi_mask,
                                      input logic [PIX_W-1:0] hi, input logic [PIX_W-1:0] lo);
    logic [PIX_W-1:0] grid [0:8];
    grid[4] = ctr;
    for (int k = 0; k < 8; k++) grid[NB_SLOT[k]] = hi_mask[k] ? hi : lo;
    @(negedge clk);
    for (int s = 0; s < 9; s++) pixel_q = {pixel_q, grid[s]};
  endtask

  task automatic wait_for_quiet();
    @(negedge clk);
    while (pixel_q.size() != 0 || pix_bus.valid || code_expect_q.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : pixel_driver
    logic fired;
    if (rst) begin
      pix_bus.valid <= 1'b0;
      pix_bus.pixel <= '0;
      gap_left = 0;
    end else begin
      fired = pix_bus.valid && pix_bus.ready;
      if (fired) begin
        lbp_take_pixel(pix_bus.pixel);
        gap_left = $urandom_range(0, send_gap_max);
      end
      // a beat on offer that was not taken stays as it is
      if (fired || !pix_bus.valid) begin
        if (gap_left > 0) begin
          pix_bus.valid <= 1'b0;
          gap_left--;
        end else if (pixel_q.size() != 0) begin
          pix_bus.valid <= 1'b1;
          pix_bus.pixel <= pixel_q.pop_front();
        end else begin
          pix_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : code_monitor
    res_t want;
    if (rst) begin
      code_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (code_bus.valid && code_bus.ready) begin
        if (code_expect_q.size() == 0) begin
          note_mismatch($sformatf("extra beat: code %02h row %0d col %0d",
                                  code_bus.pattern_code, code_bus.out_row, code_bus.out_col));
        end else begin
          want = code_expect_q.pop_front();
          if (code_bus.pattern_code !== want.code)
            note_mismatch($sformatf("(%0d,%0d) code %02h, want %02h", want.row, want.col,
                                    code_bus.pattern_code, want.code));
          if (code_bus.out_row !== want.row)
            note_mismatch($sformatf("(%0d,%0d) out_row %0d", want.row, want.col,
                                    code_bus.out_row));
          if (code_bus.out_col !== want.col)
            note_mismatch($sformatf("(%0d,%0d) out_col %0d", want.row, want.col,
                                    code_bus.out_col));
          if (code_bus.run_last !== want.run_last)
            note_mismatch($sformatf("(%0d,%0d) run_last %b, want %b", want.row, want.col,
                                    code_bus.run_last, want.run_last));
          if (code_bus.frame_done !== want.frame_done)
            note_mismatch($sformatf("(%0d,%0d) frame_done %b, want %b", want.row, want.col,
                                    code_bus.frame_done, want.frame_done));
        end
        stall_left = $urandom_range(0, recv_stall_max);
      end
      if (hold_off || stall_left > 0) begin
        code_bus.ready <= 1'b0;
        if (stall_left > 0) stall_left--;
      end else begin
        code_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int unsigned total, split;
    int random_items;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_off = 1'b0;
    mismatches = 0;
    send_gap_max = 0;
    recv_stall_max = 0;
    cfg_width = WIDTH_RESET;
    cfg_height = HEIGHT_RESET;
    for (int i = 0; i < MAXW; i++) begin
      upper_row_buf[i] = '0;
      middle_row_buf[i] = '0;
    end
    for (int i = 0; i < 6; i++) win_px[i] = '0;
    col_cnt = '0;
    row_cnt = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (4) @(posedge clk);

    // single interior pixel: alternating bits, ties, all set
    cfg_write(REG_IMAGE_WIDTH, 3);
    cfg_write(REG_IMAGE_HEIGHT, 3);
    enqueue_window_frame(8'd128, 8'h55, 8'd255, 8'd0);
    enqueue_window_frame(8'd128, 8'hAA, 8'd129, 8'd128);
    enqueue_window_frame(8'd0, 8'hFF, 8'd255, 8'd0);
    wait_for_quiet();

    // undersized width/height clamp to 3; width bits above the field are dropped
    send_gap_max <= 13;
    recv_stall_max <= 13;
    cfg_write(REG_IMAGE_WIDTH, 32'h0000_1001);
    cfg_write(REG_IMAGE_HEIGHT, 1);
    enqueue_pixels(frame_pixels_left());
    wait_for_quiet();

    // tallest frame, cut short by dropping the height mid-row
    cfg_write(REG_IMAGE_WIDTH, 3);
    cfg_write(REG_IMAGE_HEIGHT, 32'hFFFF);
    enqueue_pixels(16);
    wait_for_quiet();
    cfg_write(REG_IMAGE_HEIGHT, 0);
    enqueue_pixels(frame_pixels_left());
    wait_for_quiet();

    // width shrinks below the current column mid-row
    cfg_write(REG_IMAGE_WIDTH, 10);
    cfg_write(REG_IMAGE_HEIGHT, 6);
    enqueue_pixels(34);
    wait_for_quiet();
    cfg_write(REG_IMAGE_WIDTH, 3);
    enqueue_pixels(frame_pixels_left());
    wait_for_quiet();

    // output held off long enough to back the block up into its input
    send_gap_max <= 0;
    recv_stall_max <= 0;
    cfg_write(REG_IMAGE_WIDTH, 16);
    cfg_write(REG_IMAGE_HEIGHT, 8);
    enqueue_pixels(128);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
    wait_for_quiet();

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      send_gap_max <= $urandom_range(0, 1) ? 13 : 0;
      recv_stall_max <= $urandom_range(0, 1) ? 13 : 0;
      cfg_write(REG_IMAGE_WIDTH,
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 16));
      cfg_write(REG_IMAGE_HEIGHT,
                ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8));
      total = frame_pixels_left();
      if ($urandom_range(0, 3) == 0) begin
        // mid-frame change: any height, width only downward
        split = $urandom_range(1, total - 1);
        enqueue_pixels(split);
        random_items += split;
        wait_for_quiet();
        if ($urandom_range(0, 1))
          cfg_write(REG_IMAGE_HEIGHT, $urandom_range(0, 10));
        else
          cfg_write(REG_IMAGE_WIDTH, $urandom_range(3, eff_width()));
        total = frame_pixels_left();
      end
      enqueue_pixels(total);
      random_items += total;
      wait_for_quiet();
    end

    wait_for_quiet();
    if (code_expect_q.size() != 0)
      note_mismatch($sformatf("%0d codes never arrived", code_expect_q.size()));
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
